>>> hdl/u16r_pkg.sv
package u16r_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int FIFO_STD_DEPTH = 16;

   localparam logic [2:0] FUNC_READ = 3'd0;
   localparam logic [2:0] FUNC_WRITE = 3'd1;
   localparam logic [2:0] FUNC_LINE_BYTE = 3'd2;
   localparam logic [2:0] FUNC_TX_TICK = 3'd3;
   localparam logic [2:0] FUNC_CTS = 3'd4;

   localparam logic [2:0] REG_DATA = 3'd0;
   localparam logic [2:0] REG_IER = 3'd1;
   localparam logic [2:0] REG_IIR_FCR = 3'd2;
   localparam logic [2:0] REG_LCR = 3'd3;
   localparam logic [2:0] REG_MCR = 3'd4;
   localparam logic [2:0] REG_LSR = 3'd5;
   localparam logic [2:0] REG_MSR = 3'd6;
   localparam logic [2:0] REG_SCR = 3'd7;

   localparam logic [1:0] KIND_8250 = 2'd0;
   localparam logic [1:0] KIND_16550 = 2'd1;
   localparam logic [1:0] KIND_16750 = 2'd2;

   localparam logic [3:0] SRC_RDA = 4'h1;
   localparam logic [3:0] SRC_TDE = 4'h2;
   localparam logic [3:0] SRC_LS = 4'h4;
   localparam logic [3:0] SRC_MSC = 4'h8;

   typedef struct packed {
      logic [2:0] func;
      logic [2:0] reg_offset;
      logic [7:0] write_data;
      logic [7:0] rx_byte;
      logic       cts_level;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       irq_line;
      logic       dtr_out;
      logic       rts_out;
   } rsp_item_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [7:0] wdata;
   } fifo_ctl_type;

   function automatic logic [3:0] trig_level(input logic [1:0] sel);
      logic [3:0] t;
      unique case (sel)
         2'd0: t = 4'd1;
         2'd1: t = 4'd4;
         2'd2: t = 4'd8;
         default: t = 4'd14;
      endcase
      return t;
   endfunction

   function automatic logic [3:0] src_of_type(input logic [1:0] ty);
      logic [3:0] s;
      unique case (ty)
         2'd0: s = SRC_MSC;
         2'd1: s = SRC_TDE;
         2'd2: s = SRC_RDA;
         default: s = SRC_LS;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] upd_iir(input logic [7:0] iir, input logic [3:0] pend,
                                          input logic [3:0] ier);
      logic [3:0] act;
      logic [7:0] r;
      act = pend & ier;
      r = {iir[7:3], 3'b000};
      priority if (act[2]) r[2:1] = 2'd3;
      else if (act[0]) r[2:1] = 2'd2;
      else if (act[1]) r[2:1] = 2'd1;
      else if (act[3]) r[2:1] = 2'd0;
      else r = iir | 8'h01;
      return r;
   endfunction

endpackage

>>> hdl/u16r_fifo.sv
module u16r_fifo #(
   parameter int QD = u16r_pkg::QUEUE_DEPTH,
   localparam int CW = $clog2(QD + 1),
   localparam int PW = $clog2(QD)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  u16r_pkg::fifo_ctl_type ctl,
   input  logic [CW-1:0]          limit,
   output logic [CW-1:0]          count,
   output logic [7:0]             head
);

   logic [7:0]    mem [QD];
   logic [PW-1:0] head_ptr_ff, head_ptr_in;
   logic [PW-1:0] tail_ptr_ff, tail_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    head_data_ff, head_data_in;
   logic [7:0]    next_data_ff;
   logic [PW-1:0] rd_addr;
   logic          do_push, do_pop;

   function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
      return (p == PW'(QD - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      do_push = ctl.push && (count_ff < limit);
      do_pop = ctl.pop && (count_ff != '0);
      head_ptr_in = do_pop ? inc(head_ptr_ff) : head_ptr_ff;
      priority if (ctl.clear) tail_ptr_in = head_ptr_ff;
      else if (do_push) tail_ptr_in = inc(tail_ptr_ff);
      else tail_ptr_in = tail_ptr_ff;
      priority if (ctl.clear) count_in = '0;
      else if (do_push) count_in = count_ff + CW'(1);
      else if (do_pop) count_in = count_ff - CW'(1);
      else count_in = count_ff;
      priority if (do_push && count_ff == '0) head_data_in = ctl.wdata;
      else if (do_pop) head_data_in = next_data_ff;
      else head_data_in = head_data_ff;
      rd_addr = inc(head_ptr_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff <= '0;
         tail_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ptr_ff <= head_ptr_in;
         tail_ptr_ff <= tail_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ptr_ff] <= ctl.wdata;
      end
      if (do_push && tail_ptr_ff == rd_addr) begin
         next_data_ff <= ctl.wdata;
      end else begin
         next_data_ff <= mem[rd_addr];
      end
      head_data_ff <= head_data_in;
   end

   assign count = count_ff;
   assign head = head_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QD)) else $error("fifo count beyond depth");
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop)) else $error("push and pop in one cycle");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> count_ff == '0) else $error("clear left entries");
`endif

endmodule

>>> hdl/u16r_core.sv
module u16r_core #(
   parameter int QD = u16r_pkg::QUEUE_DEPTH,
   localparam int CW = $clog2(QD + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_wr_data,
   input  logic                   fire,
   input  u16r_pkg::req_item_type item,
   input  logic [CW-1:0]          rx_count,
   input  logic [7:0]             rx_head,
   input  logic [CW-1:0]          tx_count,
   input  logic [7:0]             tx_head,
   output logic [CW-1:0]          limit,
   output u16r_pkg::fifo_ctl_type rx_ctl,
   output u16r_pkg::fifo_ctl_type tx_ctl,
   output u16r_pkg::rsp_item_type result
);

   logic [1:0]  kind_ff;
   logic [15:0] dl_ff, dl_in;
   logic [3:0]  ier_ff, ier_in;
   logic [7:0]  lcr_ff, lcr_in;
   logic [7:0]  mcr_ff, mcr_in;
   logic [7:0]  lsr_ff, lsr_in;
   logic [7:0]  msr_ff, msr_in;
   logic [7:0]  scr_ff, scr_in;
   logic [3:0]  pend_ff, pend_in;
   logic [7:0]  iir_ff, iir_in;
   logic [7:0]  thr_ff, thr_in;
   logic [7:0]  rbr_ff, rbr_in;
   logic [3:0]  trig_ff, trig_in;

   always_comb begin
      logic          fifo_on, dlab, loopback, en, clr_rx, clr_tx, rcv;
      logic [7:0]    v, data, rcv_byte, lp;
      logic [CW-1:0] waiting, rxc, txc;
      logic [CW-1:0] small_lim;
      small_lim = (QD < u16r_pkg::FIFO_STD_DEPTH) ? CW'(QD) : CW'(u16r_pkg::FIFO_STD_DEPTH);
      limit = iir_ff[5] ? CW'(QD) : small_lim;
      fifo_on = iir_ff[7];
      dlab = lcr_ff[7];
      loopback = mcr_ff[4];
      dl_in = dl_ff; ier_in = ier_ff; lcr_in = lcr_ff; mcr_in = mcr_ff;
      lsr_in = lsr_ff; msr_in = msr_ff; scr_in = scr_ff; pend_in = pend_ff;
      iir_in = iir_ff; thr_in = thr_ff; rbr_in = rbr_ff; trig_in = trig_ff;
      rx_ctl = '0; tx_ctl = '0;
      result = '0;
      rcv = 1'b0; rcv_byte = 8'h00;
      v = 8'h00; data = 8'h00; waiting = '0;
      en = 1'b0; clr_rx = 1'b0; clr_tx = 1'b0; lp = 8'h00;
      rxc = rx_count; txc = tx_count;
      unique case (item.func)
         u16r_pkg::FUNC_READ: begin
            if (dlab && (item.reg_offset == u16r_pkg::REG_DATA
                         || item.reg_offset == u16r_pkg::REG_IER)) begin
               v = (item.reg_offset == u16r_pkg::REG_DATA) ? dl_ff[7:0] : dl_ff[15:8];
            end else begin
               unique case (item.reg_offset)
                  u16r_pkg::REG_DATA: begin
                     if (fifo_on) begin
                        if (rx_count != '0) begin
                           v = rx_head;
                           rx_ctl.pop = 1'b1;
                           waiting = rx_count - CW'(1);
                        end
                     end else begin
                        v = rbr_ff;
                        rbr_in = 8'h00;
                     end
                     lsr_in[0] = (waiting != '0);
                     if (waiting < CW'(trig_ff) && pend_ff[0]) begin
                        pend_in = pend_ff & ~u16r_pkg::SRC_RDA;
                        iir_in = u16r_pkg::upd_iir(iir_ff, pend_in, ier_ff);
                     end
                  end
                  u16r_pkg::REG_IER: v = {4'h0, ier_ff};
                  u16r_pkg::REG_IIR_FCR: begin
                     v = iir_ff;
                     pend_in = pend_ff & ~u16r_pkg::src_of_type(iir_ff[2:1]);
                     iir_in = u16r_pkg::upd_iir(iir_ff, pend_in, ier_ff);
                  end
                  u16r_pkg::REG_LCR: v = lcr_ff;
                  u16r_pkg::REG_MCR: v = mcr_ff;
                  u16r_pkg::REG_LSR: v = lsr_ff;
                  u16r_pkg::REG_MSR: begin
                     if (!loopback) begin
                        v = msr_ff;
                        msr_in = msr_ff & 8'hF4;
                     end else begin
                        lp = {mcr_ff[3], mcr_ff[2], mcr_ff[0], mcr_ff[1], 4'h0};
                        v = lp | {4'h0, msr_ff[7:4] ^ lp[7:4]};
                     end
                  end
                  default: v = (kind_ff != u16r_pkg::KIND_8250) ? scr_ff : 8'h00;
               endcase
            end
            result.read_data = v;
         end
         u16r_pkg::FUNC_WRITE: begin
            if (dlab && (item.reg_offset == u16r_pkg::REG_DATA
                         || item.reg_offset == u16r_pkg::REG_IER)) begin
               if (item.reg_offset == u16r_pkg::REG_DATA) dl_in[7:0] = item.write_data;
               else dl_in[15:8] = item.write_data;
            end else begin
               unique case (item.reg_offset)
                  u16r_pkg::REG_DATA: begin
                     if (fifo_on) begin
                        tx_ctl.push = 1'b1;
                        tx_ctl.wdata = item.write_data;
                        waiting = (tx_count < limit) ? tx_count + CW'(1) : tx_count;
                     end else begin
                        thr_in = item.write_data;
                        waiting = CW'(1);
                     end
                     lsr_in = lsr_ff & 8'h9F;
                     if (waiting > CW'(trig_ff) && pend_ff[1]) begin
                        pend_in = pend_ff & ~u16r_pkg::SRC_TDE;
                        iir_in = u16r_pkg::upd_iir(iir_ff, pend_in, ier_ff);
                     end
                  end
                  u16r_pkg::REG_IER: begin
                     ier_in = item.write_data[3:0];
                     if (lsr_ff[5]) pend_in = pend_ff | u16r_pkg::SRC_TDE;
                     iir_in = u16r_pkg::upd_iir(iir_ff, pend_in, ier_in);
                  end
                  u16r_pkg::REG_IIR_FCR: begin
                     if (kind_ff != u16r_pkg::KIND_8250) begin
                        en = item.write_data[0];
                        clr_rx = item.write_data[1];
                        clr_tx = item.write_data[2];
                        if (en != fifo_on) begin
                           clr_rx = 1'b1;
                           clr_tx = 1'b1;
                           iir_in = iir_ff & 8'h1F;
                           if (en) iir_in = iir_in | 8'hC0;
                           if (kind_ff >= u16r_pkg::KIND_16750 && item.write_data[5])
                              iir_in = iir_in | 8'h20;
                        end
                        rx_ctl.clear = clr_rx;
                        tx_ctl.clear = clr_tx;
                        if (clr_rx) rxc = '0;
                        if (clr_tx) txc = '0;
                        trig_in = en ? u16r_pkg::trig_level(item.write_data[7:6]) : 4'd1;
                        pend_in[0] = (rxc >= CW'(trig_in));
                        pend_in[1] = (txc <= CW'(trig_in));
                        iir_in = u16r_pkg::upd_iir(iir_in, pend_in, ier_ff);
                     end
                  end
                  u16r_pkg::REG_LCR: lcr_in = item.write_data;
                  u16r_pkg::REG_MCR: mcr_in = item.write_data;
                  u16r_pkg::REG_SCR: begin
                     if (kind_ff != u16r_pkg::KIND_8250) scr_in = item.write_data;
                  end
                  default: ;
               endcase
            end
         end
         u16r_pkg::FUNC_LINE_BYTE: begin
            if (!loopback) begin
               rcv = 1'b1;
               rcv_byte = item.rx_byte;
            end
         end
         u16r_pkg::FUNC_TX_TICK: begin
            if (!lsr_ff[5]) begin
               if (fifo_on) begin
                  if (tx_count != '0) begin
                     data = tx_head;
                     tx_ctl.pop = 1'b1;
                     waiting = tx_count - CW'(1);
                  end
               end else begin
                  data = thr_ff;
               end
               if (!loopback) begin
                  result.tx_valid = 1'b1;
                  result.tx_byte = data;
               end
               lsr_in[6:5] = (waiting == '0) ? 2'b11 : 2'b00;
               if (waiting <= CW'(trig_ff)) begin
                  pend_in = pend_ff | u16r_pkg::SRC_TDE;
                  iir_in = u16r_pkg::upd_iir(iir_ff, pend_in, ier_ff);
               end
               if (loopback) begin
                  rcv = 1'b1;
                  rcv_byte = data;
               end
            end
         end
         u16r_pkg::FUNC_CTS: begin
            if (msr_ff[4] != item.cts_level) msr_in = (msr_ff ^ 8'h10) | 8'h01;
         end
         default: ;
      endcase
      if (rcv) begin
         if (fifo_on) begin
            rx_ctl.push = 1'b1;
            rx_ctl.wdata = rcv_byte;
            waiting = (rx_count < limit) ? rx_count + CW'(1) : rx_count;
         end else begin
            rbr_in = rcv_byte;
            waiting = CW'(1);
         end
         lsr_in[0] = 1'b1;
         if (waiting >= CW'(trig_ff)) begin
            pend_in = pend_in | u16r_pkg::SRC_RDA;
            iir_in = u16r_pkg::upd_iir(iir_in, pend_in, ier_ff);
         end
      end
      if (!fire) begin
         rx_ctl = '0;
         tx_ctl = '0;
      end
      result.irq_line = |(pend_in & ier_in);
      result.dtr_out = mcr_in[0];
      result.rts_out = mcr_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= u16r_pkg::KIND_16550;
         ier_ff <= '0;
         lcr_ff <= '0;
         mcr_ff <= '0;
         lsr_ff <= 8'h60;
         msr_ff <= '0;
         scr_ff <= '0;
         pend_ff <= u16r_pkg::SRC_TDE;
         iir_ff <= '0;
         thr_ff <= '0;
         rbr_ff <= '0;
         trig_ff <= 4'd1;
      end else begin
         if (csr_wr_en) kind_ff <= csr_wr_data;
         if (fire) begin
            ier_ff <= ier_in;
            lcr_ff <= lcr_in;
            mcr_ff <= mcr_in;
            lsr_ff <= lsr_in;
            msr_ff <= msr_in;
            scr_ff <= scr_in;
            pend_ff <= pend_in;
            iir_ff <= iir_in;
            thr_ff <= thr_in;
            rbr_ff <= rbr_in;
            trig_ff <= trig_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) dl_ff <= dl_in;
   end

endmodule

>>> hdl/uart_16550_register_model_top.sv
// path: req word into stage register, rsp word into output register
// throughput: one word per cycle unless rsp_ready stalls, set by the
// combinational register update and the fifo head prefetch register
// reset: synchronous active high; clears control registers, fifo counts and
// pointers; fifo storage and divisor latch are not cleared
module uart_16550_register_model_top #(
   parameter int QUEUE_DEPTH = u16r_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_rx_byte,
   input  logic       req_cts_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_irq_line,
   output logic       rsp_dtr_out,
   output logic       rsp_rts_out
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                   stg_valid_ff, stg_valid_in;
   u16r_pkg::req_item_type stg_item_ff;
   logic                   out_valid_ff, out_valid_in;
   u16r_pkg::rsp_item_type out_item_ff, result;
   logic                   advance, fire, take;
   logic [CW-1:0]          limit, rx_count, tx_count;
   logic [7:0]             rx_head, tx_head;
   u16r_pkg::fifo_ctl_type rx_ctl, tx_ctl;

   assign advance = !out_valid_ff || rsp_ready;
   assign fire = stg_valid_ff && advance;
   assign req_ready = !stg_valid_ff || advance;
   assign take = req_valid && req_ready;

   always_comb begin
      stg_valid_in = take ? 1'b1 : (fire ? 1'b0 : stg_valid_ff);
      out_valid_in = advance ? stg_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stg_item_ff <= '{func: req_func, reg_offset: req_reg_offset,
                          write_data: req_write_data, rx_byte: req_rx_byte,
                          cts_level: req_cts_level};
      end
      if (fire) out_item_ff <= result;
   end

   u16r_core #(.QD(QUEUE_DEPTH)) u_core (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fire(fire), .item(stg_item_ff),
      .rx_count(rx_count), .rx_head(rx_head),
      .tx_count(tx_count), .tx_head(tx_head),
      .limit(limit), .rx_ctl(rx_ctl), .tx_ctl(tx_ctl), .result(result)
   );

   u16r_fifo #(.QD(QUEUE_DEPTH)) u_rx_fifo (
      .clock(clock), .reset(reset), .ctl(rx_ctl), .limit(limit),
      .count(rx_count), .head(rx_head)
   );

   u16r_fifo #(.QD(QUEUE_DEPTH)) u_tx_fifo (
      .clock(clock), .reset(reset), .ctl(tx_ctl), .limit(limit),
      .count(tx_count), .head(tx_head)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_read_data = out_item_ff.read_data;
   assign rsp_tx_valid = out_item_ff.tx_valid;
   assign rsp_tx_byte = out_item_ff.tx_byte;
   assign rsp_irq_line = out_item_ff.irq_line;
   assign rsp_dtr_out = out_item_ff.dtr_out;
   assign rsp_rts_out = out_item_ff.rts_out;

endmodule
